[hdl/wpc_pkg.sv]
// Shared types, constants and codes for the windowed page cache policy block.
package wpc_pkg;

  // Cache geometry and page sizing
  localparam int CACHE_ENTRIES  = 2;
  localparam int CARDS_PER_PAGE = 9;
  localparam int NEXT_PAGES_MAX = 2;

  localparam int IDX_W    = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int PAGE_W   = 8;
  localparam int SLOT_W   = 4;
  localparam int AGE_W    = 32;
  localparam int PHOTO_W  = 8;

  // Page count = ceil(photos / CARDS_PER_PAGE) by reciprocal multiply
  localparam int SUM_W     = PHOTO_W + 1;
  localparam int DIV_SHIFT = 16;
  localparam int DIV_RECIP = (1 << DIV_SHIFT) / CARDS_PER_PAGE + 1;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;

  // Request type codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_SHOW  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_NO_ENTRY = 2'd2
  } status_t;

  // Input word
  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] target_page;
  } req_t;

  // Result word
  typedef struct packed {
    status_t           status;
    logic [PAGE_W-1:0] page_number;
    logic [SLOT_W-1:0] slot_index;
    logic              was_hit;
    logic              last_result;
  } result_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             calc_pages;
    logic             check;
    logic             window;
    logic             prio_init;
    logic             scan_step;
    logic             decide;
    logic             same;
    logic             last;
    logic [IDX_W-1:0] pr_idx;
    logic [IDX_W-1:0] scan_idx;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic invalid;
    logic same_page;
    logic fail;
  } stat_t;

endpackage

[hdl/wpc_ctrl.sv]
// Request sequencer: steps through checks, window setup, priority pages and entry scans.
module wpc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  wpc_pkg::stat_t stat,
  output wpc_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PAGES  = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_WINDOW = 7'b0001000,
    S_PRIO   = 7'b0010000,
    S_SCAN   = 7'b0100000,
    S_DECIDE = 7'b1000000
  } state_t;

  localparam logic [wpc_pkg::IDX_W-1:0] IDX_LAST =
    wpc_pkg::IDX_W'(wpc_pkg::CACHE_ENTRIES - 1);

  state_t                     state, state_next;
  logic [wpc_pkg::IDX_W-1:0]  pr_idx, pr_idx_next;
  logic [wpc_pkg::IDX_W-1:0]  scan_idx, scan_idx_next;
  logic                       same_mode, same_mode_next;
  logic                       pr_last;

  assign busy    = (state != S_IDLE);
  assign pr_last = (pr_idx == IDX_LAST);

  // Decode state into commands and pick the next state
  always_comb begin
    state_next     = state;
    pr_idx_next    = pr_idx;
    scan_idx_next  = scan_idx;
    same_mode_next = same_mode;
    cmd            = '0;
    cmd.pr_idx     = pr_idx;
    cmd.scan_idx   = scan_idx;
    cmd.same       = same_mode;
    cmd.last       = same_mode || pr_last;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_PAGES;
        end
      end
      S_PAGES: begin
        cmd.calc_pages = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        cmd.check   = 1'b1;
        pr_idx_next = '0;
        priority if (stat.invalid) begin
          state_next = S_IDLE;
        end else if (stat.same_page) begin
          same_mode_next = 1'b1;
          state_next     = S_PRIO;
        end else begin
          same_mode_next = 1'b0;
          state_next     = S_WINDOW;
        end
      end
      S_WINDOW: begin
        cmd.window = 1'b1;
        state_next = S_PRIO;
      end
      S_PRIO: begin
        cmd.prio_init = 1'b1;
        scan_idx_next = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (scan_idx == IDX_LAST) begin
          state_next = S_DECIDE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (same_mode || stat.fail || pr_last) begin
          state_next = S_IDLE;
        end else begin
          pr_idx_next = pr_idx + 1'b1;
          state_next  = S_PRIO;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pr_idx    <= '0;
      scan_idx  <= '0;
      same_mode <= 1'b0;
    end else begin
      state     <= state_next;
      pr_idx    <= pr_idx_next;
      scan_idx  <= scan_idx_next;
      same_mode <= same_mode_next;
    end
  end

  // The final decision of a request always returns to idle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && cmd.last) |=> (state == S_IDLE))
    else $error("request did not end after its final decision");

endmodule

[hdl/wpc_dp.sv]
// Cache datapath: page count, window bounds, entry table, LRU ages and result register.
module wpc_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  wpc_pkg::req_t                 req,
  input  logic                          album_size_we,
  input  logic [wpc_pkg::PHOTO_W-1:0]   album_size,
  input  wpc_pkg::cmd_t                 cmd,
  output wpc_pkg::stat_t                stat,
  output logic                          result_strobe,
  output wpc_pkg::result_t              result
);

  localparam logic [wpc_pkg::PAGE_W-1:0] N_PAGES  = wpc_pkg::PAGE_W'(wpc_pkg::CACHE_ENTRIES);
  localparam logic [wpc_pkg::PAGE_W-1:0] NEXT_MAX = wpc_pkg::PAGE_W'(wpc_pkg::NEXT_PAGES_MAX);

  // Configuration and request
  logic [wpc_pkg::PHOTO_W-1:0]  photos;
  wpc_pkg::req_t                req_q;
  logic [wpc_pkg::PAGE_W-1:0]   pages;

  // Block state
  logic [wpc_pkg::CACHE_ENTRIES-1:0] entry_valid;
  logic [wpc_pkg::PAGE_W-1:0]        entry_page [wpc_pkg::CACHE_ENTRIES];
  logic [wpc_pkg::AGE_W-1:0]         entry_age  [wpc_pkg::CACHE_ENTRIES];
  logic [wpc_pkg::AGE_W-1:0]         use_clock;
  logic [wpc_pkg::PAGE_W-1:0]        shown_page;
  logic [wpc_pkg::PAGE_W-1:0]        page_total;
  logic                              running;

  // Per request working registers
  logic [wpc_pkg::PAGE_W-1:0]  win_start;
  logic [wpc_pkg::PAGE_W-1:0]  win_end;
  logic [wpc_pkg::PAGE_W-1:0]  next_lim;
  logic [wpc_pkg::PAGE_W-1:0]  prio_page;
  logic                        hit_f, inv_f, old_f;
  logic [wpc_pkg::IDX_W-1:0]   hit_idx, inv_idx, old_idx;
  logic [wpc_pkg::AGE_W-1:0]   old_age;

  logic                        is_start;
  logic [wpc_pkg::PAGE_W-1:0]  center;
  logic [wpc_pkg::PROD_W-1:0]  pages_prod;
  logic                        invalid;
  logic                        fail;
  logic [wpc_pkg::PAGE_W-1:0]  ws_lo, ws_max, ws, wc, we, nx;
  logic [wpc_pkg::PAGE_W-1:0]  pr8, prio_calc;
  logic                        sv, inw;
  logic [wpc_pkg::PAGE_W-1:0]  sp;
  logic [wpc_pkg::AGE_W-1:0]   sa;
  logic [wpc_pkg::AGE_W-1:0]   clk_inc, clk_new;
  logic [wpc_pkg::IDX_W-1:0]   sel_idx;
  logic                        start_ok;

  assign is_start = (req_q.req_type == wpc_pkg::REQ_START);
  assign center   = req_q.target_page;

  // Ceiling division by reciprocal multiply
  assign pages_prod = wpc_pkg::PROD_W'(wpc_pkg::SUM_W'(photos)
                      + wpc_pkg::SUM_W'(wpc_pkg::CARDS_PER_PAGE - 1))
                      * wpc_pkg::PROD_W'(wpc_pkg::DIV_RECIP);

  // Request checks
  assign invalid  = is_start ? (pages == '0 || center >= pages)
                             : (!running || center >= page_total);
  assign start_ok = is_start && !invalid;
  assign stat.invalid   = invalid;
  assign stat.same_page = !is_start && (center == shown_page);
  assign fail           = !hit_f && !inv_f && !old_f;
  assign stat.fail      = fail;

  // Window bounds around the center page
  always_comb begin
    ws_lo  = (center != '0) ? center - 1'b1 : '0;
    ws_max = (page_total > N_PAGES) ? page_total - N_PAGES : '0;
    ws     = (ws_lo > ws_max) ? ws_max : ws_lo;
    wc     = (page_total < N_PAGES) ? page_total : N_PAGES;
    we     = ws + wc;
    nx     = we - center - 1'b1;
    if (center != ws && nx > NEXT_MAX) begin
      nx = NEXT_MAX;
    end
  end

  // Priority page: center, then following pages, then earlier ones
  always_comb begin
    pr8 = wpc_pkg::PAGE_W'(cmd.pr_idx);
    if (pr8 >= page_total || pr8 == '0) begin
      prio_calc = center;
    end else if (pr8 <= next_lim) begin
      prio_calc = center + pr8;
    end else begin
      prio_calc = center - (pr8 - next_lim);
    end
  end

  // Entry under scan
  assign sv  = entry_valid[cmd.scan_idx];
  assign sp  = entry_page[cmd.scan_idx];
  assign sa  = entry_age[cmd.scan_idx];
  assign inw = (sp >= win_start) && (sp < win_end);

  // Age clock skips zero on wrap
  assign clk_inc = use_clock + 1'b1;
  assign clk_new = (clk_inc == '0) ? wpc_pkg::AGE_W'(1) : clk_inc;

  // Hit, else first free entry, else oldest entry outside the window
  always_comb begin
    priority if (hit_f) begin
      sel_idx = hit_idx;
    end else if (inv_f) begin
      sel_idx = inv_idx;
    end else begin
      sel_idx = old_idx;
    end
  end

  // Control state: configuration, entry valid bits, clock, shown page, page total, running flag, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      photos        <= '0;
      entry_valid   <= '0;
      use_clock     <= '0;
      shown_page    <= '0;
      page_total    <= '0;
      running       <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      // Pulse the strobe for an invalid request's check word and for each decision word
      result_strobe <= (cmd.check && invalid) || cmd.decide;
      if (album_size_we) begin
        photos <= album_size;
      end
      if (cmd.check) begin
        if (!invalid && is_start) begin
          entry_valid <= '0;
          use_clock   <= '0;
          page_total  <= pages;
          shown_page  <= center;
          running     <= 1'b1;
        end
      end
      if (cmd.decide) begin
        if (!cmd.same) begin
          if (fail) begin
            // drop everything after a failed start
            if (is_start) begin
              entry_valid <= '0;
              use_clock   <= '0;
              shown_page  <= '0;
              page_total  <= '0;
              running     <= 1'b0;
            end
          end else begin
            entry_valid[sel_idx] <= 1'b1;
            use_clock            <= clk_new;
            if (cmd.last && !is_start) begin
              shown_page <= center;
            end
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.calc_pages) begin
      pages <= pages_prod[wpc_pkg::DIV_SHIFT +: wpc_pkg::PAGE_W];
    end
    if (cmd.check) begin
      result <= '{status: wpc_pkg::ST_INVALID, page_number: center,
                  slot_index: '0, was_hit: 1'b0, last_result: 1'b1};
    end
    if (cmd.window) begin
      win_start <= ws;
      win_end   <= we;
      next_lim  <= nx;
    end
    if (cmd.prio_init) begin
      prio_page <= prio_calc;
      hit_f     <= 1'b0;
      inv_f     <= 1'b0;
      old_f     <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (sv && sp == prio_page && !hit_f) begin
        hit_f   <= 1'b1;
        hit_idx <= cmd.scan_idx;
      end
      if (!sv && !inv_f) begin
        inv_f   <= 1'b1;
        inv_idx <= cmd.scan_idx;
      end
      if (sv && !inw && (!old_f || sa < old_age)) begin
        old_f   <= 1'b1;
        old_idx <= cmd.scan_idx;
        old_age <= sa;
      end
    end
    if (cmd.decide) begin
      if (cmd.same) begin
        result <= '{status: wpc_pkg::ST_OK, page_number: center,
                    slot_index: hit_f ? wpc_pkg::SLOT_W'(hit_idx) : '0,
                    was_hit: hit_f, last_result: 1'b1};
      end else if (fail) begin
        result <= '{status: wpc_pkg::ST_NO_ENTRY, page_number: prio_page,
                    slot_index: '0, was_hit: 1'b0, last_result: 1'b1};
      end else begin
        entry_page[sel_idx] <= prio_page;
        entry_age[sel_idx]  <= clk_new;
        result <= '{status: wpc_pkg::ST_OK, page_number: prio_page,
                    slot_index: wpc_pkg::SLOT_W'(sel_idx),
                    was_hit: hit_f, last_result: cmd.last};
      end
    end
  end

  // Any non-ok result closes its request
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.status != wpc_pkg::ST_OK) |-> result.last_result)
    else $error("error result not marked final");

  // A valid entry implies the age clock has ticked
  a_clock_live: assert property (@(posedge clk) disable iff (rst)
    (|entry_valid) |-> (use_clock != '0))
    else $error("valid entry with idle age clock");

  // A reported hit names a valid entry
  a_hit_valid: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.was_hit) |->
      entry_valid[result.slot_index[wpc_pkg::IDX_W-1:0]])
    else $error("hit reported on an invalid entry");

endmodule

[hdl/windowed_page_cache_policy.sv]
// Top level of the windowed page cache policy: sequencer plus cache datapath.
// An invalid request gives its word at the check; a show of the current page skips the
// window setup and makes one priority-page scan; a full reconcile runs the
// one-entry-per-cycle LRU scan once for each priority page, up to CACHE_ENTRIES of them.
// One request at a time; busy falls as the final word is registered.
// Synchronous reset empties the cache.
module windowed_page_cache_policy (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  wpc_pkg::req_t                req,
  output logic                         busy,
  input  logic                         album_size_we,
  input  logic [wpc_pkg::PHOTO_W-1:0]  album_size,
  output logic                         result_strobe,
  output wpc_pkg::result_t             result
);

  wpc_pkg::cmd_t  cmd;
  wpc_pkg::stat_t stat;

  // Sequencer
  wpc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath
  wpc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .album_size_we  (album_size_we),
    .album_size     (album_size),
    .cmd            (cmd),
    .stat           (stat),
    .result_strobe  (result_strobe),
    .result         (result)
  );

endmodule
